>>> src/gbfr_pkg.sv
// Shared types and constants for the binary GPS frame receiver.
package gbfr_pkg;

    localparam int RESULT_WIDTH = 232;

    localparam logic [7:0] SYNC_FIRST  = 8'hA0;
    localparam logic [7:0] SYNC_SECOND = 8'hA1;
    localparam logic [7:0] LEN_HIGH    = 8'h00;
    localparam logic [7:0] TAIL_FIRST  = 8'h0D;
    localparam logic [7:0] TAIL_SECOND = 8'h0A;
    localparam logic [7:0] MAX_PAYLOAD = 8'd61;
    localparam logic [6:0] TRAILER_LEN = 7'd3;

    localparam logic [5:0] OFS_MSG_ID = 6'd0;
    localparam logic [5:0] OFS_FIX    = 6'd1;
    localparam logic [5:0] OFS_SATS   = 6'd2;
    localparam logic [5:0] OFS_LAT    = 6'd9;
    localparam logic [5:0] OFS_LON    = 6'd13;
    localparam logic [5:0] OFS_ALT    = 6'd21;
    localparam logic [5:0] OFS_DOP    = 6'd27;
    localparam logic [5:0] OFS_VEL_X  = 6'd47;
    localparam logic [5:0] OFS_VEL_Y  = 6'd51;
    localparam logic [5:0] OFS_VEL_Z  = 6'd55;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [1:0] CFG_POWER_DELAY  = 2'd0;
    localparam logic [1:0] CFG_LINK_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_NAV_ID       = 2'd2;

    localparam logic [15:0] POWER_DELAY_RESET  = 16'd1000;
    localparam logic [15:0] LINK_TIMEOUT_RESET = 16'd2500;
    localparam logic [7:0]  NAV_ID_RESET       = 8'hA8;

    typedef enum logic [1:0] {
        LINK_UP   = 2'd0,
        LINK_NAV  = 2'd1,
        LINK_DOWN = 2'd2
    } link_state_t;

    typedef struct packed {
        logic [7:0]  msg_id;
        logic [7:0]  fix_type;
        logic [7:0]  sats;
        logic [31:0] lat;
        logic [31:0] lon;
        logic [31:0] alt;
        logic [15:0] dop;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
    } nav_fields_t;

endpackage

>>> src/gbfr_framer.sv
// Byte framer with checksum check and capture of the navigation fields.
module gbfr_framer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_en,
    input  logic [7:0]           rx_byte,
    output logic                 frame_ok,
    output gbfr_pkg::nav_fields_t fields
);
    import gbfr_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_GOT_A0,
        PH_GOT_A1,
        PH_GOT_LEN_HIGH,
        PH_BODY
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [6:0]  left_reg, left_next;
    logic [7:0]  csum_reg, csum_next;
    logic [5:0]  index_reg, index_next;
    logic [7:0]  prev1_reg, prev1_next;
    logic [7:0]  prev2_reg, prev2_next;
    nav_fields_t store_reg, store_next;

    function automatic logic [31:0] put_be32(logic [31:0] word, logic [5:0] base,
                                             logic [5:0] idx, logic [7:0] data);
        logic [5:0]  k;
        logic [31:0] res;
        k   = idx - base;
        res = word;
        if (idx >= base && k < 6'd4) begin
            case (k[1:0])
                2'd0:    res[31:24] = data;
                2'd1:    res[23:16] = data;
                2'd2:    res[15:8]  = data;
                default: res[7:0]   = data;
            endcase
        end
        return res;
    endfunction

    function automatic logic [15:0] put_be16(logic [15:0] word, logic [5:0] base,
                                             logic [5:0] idx, logic [7:0] data);
        logic [5:0]  k;
        logic [15:0] res;
        k   = idx - base;
        res = word;
        if (idx >= base && k < 6'd2) begin
            if (k[0]) begin
                res[7:0] = data;
            end else begin
                res[15:8] = data;
            end
        end
        return res;
    endfunction

    always_comb begin
        phase_next = phase_reg;
        left_next  = left_reg;
        csum_next  = csum_reg;
        index_next = index_reg;
        prev1_next = prev1_reg;
        prev2_next = prev2_reg;
        store_next = store_reg;
        frame_ok   = 1'b0;
        if (byte_en) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (rx_byte == SYNC_FIRST) begin
                        phase_next = PH_GOT_A0;
                    end
                end
                PH_GOT_A0: begin
                    phase_next = (rx_byte == SYNC_SECOND) ? PH_GOT_A1 : PH_IDLE;
                end
                PH_GOT_A1: begin
                    phase_next = (rx_byte == LEN_HIGH) ? PH_GOT_LEN_HIGH : PH_IDLE;
                end
                PH_GOT_LEN_HIGH: begin
                    if (rx_byte <= MAX_PAYLOAD) begin
                        left_next  = rx_byte[6:0] + TRAILER_LEN;
                        index_next = '0;
                        csum_next  = '0;
                        phase_next = PH_BODY;
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_BODY: begin
                    if (index_reg == OFS_MSG_ID) begin
                        store_next.msg_id = rx_byte;
                    end
                    if (index_reg == OFS_FIX) begin
                        store_next.fix_type = rx_byte;
                    end
                    if (index_reg == OFS_SATS) begin
                        store_next.sats = rx_byte;
                    end
                    store_next.lat   = put_be32(store_reg.lat, OFS_LAT, index_reg, rx_byte);
                    store_next.lon   = put_be32(store_reg.lon, OFS_LON, index_reg, rx_byte);
                    store_next.alt   = put_be32(store_reg.alt, OFS_ALT, index_reg, rx_byte);
                    store_next.dop   = put_be16(store_reg.dop, OFS_DOP, index_reg, rx_byte);
                    store_next.vel_x = put_be32(store_reg.vel_x, OFS_VEL_X, index_reg, rx_byte);
                    store_next.vel_y = put_be32(store_reg.vel_y, OFS_VEL_Y, index_reg, rx_byte);
                    store_next.vel_z = put_be32(store_reg.vel_z, OFS_VEL_Z, index_reg, rx_byte);
                    index_next = index_reg + 6'd1;
                    prev1_next = rx_byte;
                    prev2_next = prev1_reg;
                    if (left_reg > TRAILER_LEN) begin
                        csum_next = csum_reg ^ rx_byte;
                    end
                    if (left_reg != '0) begin
                        left_next = left_reg - 7'd1;
                    end
                    if (left_next == '0) begin
                        phase_next = PH_IDLE;
                        frame_ok   = (prev2_reg == csum_reg) && (prev1_reg == TAIL_FIRST) &&
                                     (rx_byte == TAIL_SECOND);
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    assign fields = store_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            left_reg  <= '0;
            csum_reg  <= '0;
            index_reg <= '0;
            store_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            csum_reg  <= csum_next;
            index_reg <= index_next;
            store_reg <= store_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev1_reg <= prev1_next;
        prev2_reg <= prev2_next;
    end

endmodule

>>> src/gbfr_watchdog.sv
// Power-cycle watchdog driven by millisecond ticks.
module gbfr_watchdog (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  tick_en,
    input  logic                  clear_en,
    input  logic [15:0]           power_delay,
    input  logic [15:0]           link_timeout,
    output gbfr_pkg::link_state_t link_state,
    output gbfr_pkg::link_state_t link_state_next
);
    import gbfr_pkg::*;

    link_state_t link_reg, link_next;
    logic [15:0] ticks_reg, ticks_next;
    logic [15:0] ticks_inc;

    always_comb begin
        ticks_inc  = (ticks_reg == 16'hFFFF) ? ticks_reg : ticks_reg + 16'd1;
        ticks_next = ticks_reg;
        link_next  = link_reg;
        if (tick_en) begin
            ticks_next = ticks_inc;
            if (ticks_inc > link_timeout && link_reg != LINK_DOWN) begin
                link_next  = LINK_DOWN;
                ticks_next = '0;
            end else if (ticks_inc > power_delay) begin
                case (link_reg)
                    LINK_DOWN: begin
                        link_next  = LINK_UP;
                        ticks_next = '0;
                    end
                    LINK_UP: begin
                        link_next  = LINK_NAV;
                        ticks_next = '0;
                    end
                    default: begin
                        link_next = link_reg;
                    end
                endcase
            end
        end else if (clear_en) begin
            ticks_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg  <= LINK_DOWN;
            ticks_reg <= '0;
        end else begin
            link_reg  <= link_next;
            ticks_reg <= ticks_next;
        end
    end

    assign link_state      = link_reg;
    assign link_state_next = link_next;

endmodule

>>> src/gps_binary_frame_receiver.sv
// Top level of the binary GPS frame receiver with power-cycle watchdog.
// Each request on the slave side is a received byte (tuser 0) or a millisecond tick (tuser 1)
// and yields exactly one result on the master side. A request is registered on entry and its
// result registered on exit, so a request passes the input register and then the output register
// before its result is offered; one request is taken every cycle while the result side keeps up;
// the framer, field capture and watchdog all settle in the single logic step between those two
// registers. Navigation fields are captured as payload bytes arrive, and a frame that completes
// while navigating with the nav message id raises tuser on its result.
module gps_binary_frame_receiver (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // rx_byte
    input  logic [0:0]                        s_tuser,   // command
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // power_state[1:0], position_valid[2], fix_type[10:3], satellite_count[18:11],
    // latitude[49:19], longitude[81:50], sea_level_altitude[113:82], position_dop[129:114],
    // velocity_x[161:130], velocity_y[193:162], velocity_z[225:194], zero[231:226]
    output logic [gbfr_pkg::RESULT_WIDTH-1:0] m_tdata,
    output logic [0:0]                        m_tuser,   // report_valid
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [15:0]                       cfg_data
);
    import gbfr_pkg::*;

    logic        in_valid_reg;
    logic        in_cmd_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    logic [RESULT_WIDTH-1:0] out_data_reg, out_data_next;
    logic        out_report_reg;
    logic [15:0] power_delay_reg;
    logic [15:0] link_timeout_reg;
    logic [7:0]  nav_id_reg;

    logic        advance;
    logic        process;
    logic        byte_en;
    logic        tick_en;
    logic        frame_ok;
    logic        report;
    logic        fix;
    nav_fields_t fields;
    link_state_t link_state;
    link_state_t link_state_next;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = aresetn && (!in_valid_reg || advance);
    assign process  = in_valid_reg && advance;
    assign byte_en  = process && (in_cmd_reg == CMD_BYTE);
    assign tick_en  = process && (in_cmd_reg == CMD_TICK);
    assign cfg_ready = aresetn;

    gbfr_framer u_framer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .byte_en  (byte_en),
        .rx_byte  (in_byte_reg),
        .frame_ok (frame_ok),
        .fields   (fields)
    );

    assign report = byte_en && frame_ok && (link_state == LINK_NAV) &&
                    (fields.msg_id == nav_id_reg);

    gbfr_watchdog u_watchdog (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .tick_en         (tick_en),
        .clear_en        (report),
        .power_delay     (power_delay_reg),
        .link_timeout    (link_timeout_reg),
        .link_state      (link_state),
        .link_state_next (link_state_next)
    );

    always_comb begin
        fix = report && (fields.fix_type != 8'd0);
        out_data_next = {
            6'd0,
            fix    ? fields.vel_z    : 32'd0,
            fix    ? fields.vel_y    : 32'd0,
            fix    ? fields.vel_x    : 32'd0,
            report ? fields.dop      : 16'd0,
            fix    ? fields.alt      : 32'd0,
            fix    ? fields.lon      : 32'd0,
            fix    ? fields.lat[30:0] : 31'd0,
            report ? fields.sats     : 8'd0,
            report ? fields.fix_type : 8'd0,
            fix,
            link_state_next
        };
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            power_delay_reg  <= POWER_DELAY_RESET;
            link_timeout_reg <= LINK_TIMEOUT_RESET;
            nav_id_reg       <= NAV_ID_RESET;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_POWER_DELAY:  power_delay_reg  <= cfg_data;
                    CFG_LINK_TIMEOUT: link_timeout_reg <= cfg_data;
                    CFG_NAV_ID:       nav_id_reg       <= cfg_data[7:0];
                    default:          nav_id_reg       <= nav_id_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg  <= s_tuser[0];
            in_byte_reg <= s_tdata;
        end
        if (process) begin
            out_data_reg   <= out_data_next;
            out_report_reg <= report;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_report_reg;

endmodule

>>> src/gbfr_checker.sv
// Port-level assertions for the binary GPS frame receiver, bound to the top level.
module gbfr_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [gbfr_pkg::RESULT_WIDTH-1:0] m_tdata,
    input logic [0:0]                        m_tuser
);
    import gbfr_pkg::*;

    a_report_only_navigating: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[1:0] == LINK_NAV)
        else $error("report given outside navigating state");

    a_power_state_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("illegal power state");

    a_no_report_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[RESULT_WIDTH-1:2] == '0)
        else $error("fields set without a report");

    a_no_fix_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[2] |-> m_tdata[113:19] == '0 && m_tdata[231:130] == '0)
        else $error("position fields set without a fix");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind gps_binary_frame_receiver gbfr_checker u_gbfr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> sim/tb_top.sv
// Self-checking bench for the GPS binary frame receiver: framing, nav reports and link watchdog.
`timescale 1ns / 1ps

module tb_top;
    import gbfr_pkg::*;

    localparam int STALL_LIMIT = 3000;

    class nav_report_scoreboard;
        typedef enum {HUNT, SAW_SYNC1, SAW_SYNC2, SAW_LEN_HIGH, IN_BODY} framer_phase_e;

        typedef struct packed {
            logic [1:0]  power_state;
            logic        report;
            logic        pos_valid;
            logic [7:0]  fix;
            logic [7:0]  sats;
            logic [30:0] lat;
            logic [31:0] lon;
            logic [31:0] alt;
            logic [15:0] dop;
            logic [31:0] vel_x;
            logic [31:0] vel_y;
            logic [31:0] vel_z;
        } nav_result_t;

        logic [15:0]   power_delay;
        logic [15:0]   link_timeout;
        logic [7:0]    nav_id;
        framer_phase_e phase;
        int            bytes_left;
        logic [7:0]    checksum;
        logic [5:0]    store_idx;
        logic [7:0]    store [64];
        link_state_t   link;
        logic [15:0]   ticks;
        nav_result_t   expected_results[$];
        int            errors;

        function new();
            power_delay  = POWER_DELAY_RESET;
            link_timeout = LINK_TIMEOUT_RESET;
            nav_id       = NAV_ID_RESET;
            phase        = HUNT;
            bytes_left   = 0;
            checksum     = '0;
            store_idx    = '0;
            foreach (store[i]) store[i] = '0;
            link         = LINK_DOWN;
            ticks        = '0;
            errors       = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                CFG_POWER_DELAY:  power_delay = val;
                CFG_LINK_TIMEOUT: link_timeout = val;
                CFG_NAV_ID:       nav_id = val[7:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] word_at(int pos);
            return {store[pos], store[pos + 1], store[pos + 2], store[pos + 3]};
        endfunction

        function void advance_watchdog();
            if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
            if (ticks > link_timeout && link != LINK_DOWN) begin
                link  = LINK_DOWN;
                ticks = '0;
            end else if (ticks > power_delay) begin
                if (link == LINK_DOWN) begin
                    link  = LINK_UP;
                    ticks = '0;
                end else if (link == LINK_UP) begin
                    link  = LINK_NAV;
                    ticks = '0;
                end
            end
        endfunction

        function bit take_byte(logic [7:0] ch);
            bit done;
            done = 1'b0;
            if (phase == HUNT && ch == SYNC_FIRST) begin
                phase = SAW_SYNC1;
            end else if (phase == SAW_SYNC1 && ch == SYNC_SECOND) begin
                phase = SAW_SYNC2;
            end else if (phase == SAW_SYNC2 && ch == LEN_HIGH) begin
                phase = SAW_LEN_HIGH;
            end else if (phase == SAW_LEN_HIGH && ch <= MAX_PAYLOAD) begin
                bytes_left = int'(ch) + int'(TRAILER_LEN);
                store_idx  = '0;
                checksum   = '0;
                phase      = IN_BODY;
            end else if (phase == IN_BODY) begin
                store[store_idx] = ch;
                store_idx = store_idx + 6'd1;
                if (bytes_left > int'(TRAILER_LEN)) checksum = checksum ^ ch;
                if (bytes_left > 0) bytes_left--;
                if (bytes_left == 0) begin
                    done = store[store_idx - 6'd3] == checksum &&
                           store[store_idx - 6'd2] == TAIL_FIRST &&
                           store[store_idx - 6'd1] == TAIL_SECOND;
                    phase = HUNT;
                end
            end else begin
                phase = HUNT;
            end
            return done;
        endfunction

        function void note_request(logic cmd, logic [7:0] ch);
            nav_result_t r;
            logic [31:0] w;
            r = '0;
            if (cmd == CMD_TICK) begin
                advance_watchdog();
            end else if (take_byte(ch) && link == LINK_NAV && store[0] == nav_id) begin
                r.report = 1'b1;
                r.fix    = store[1];
                r.sats   = store[2];
                r.dop    = {store[27], store[28]};
                if (store[1] != 8'd0) begin
                    r.pos_valid = 1'b1;
                    w           = word_at(9);
                    r.lat       = w[30:0];
                    r.lon       = word_at(13);
                    r.alt       = word_at(21);
                    r.vel_x     = word_at(47);
                    r.vel_y     = word_at(51);
                    r.vel_z     = word_at(55);
                end
                ticks = '0;
            end
            r.power_state = link;
            expected_results.push_back(r);
        endfunction

        function void compare_field(string label, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t %s expected %h actual %h", $time, label, want, got);
            end
        endfunction

        function void check_result(logic [RESULT_WIDTH-1:0] d, logic rep);
            nav_result_t w;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t result with nothing expected: tuser %b tdata %h", $time, rep, d);
                return;
            end
            w = expected_results.pop_front();
            compare_field("power_state", 32'(w.power_state), 32'(d[1:0]));
            compare_field("report_valid", 32'(w.report), 32'(rep));
            compare_field("position_valid", 32'(w.pos_valid), 32'(d[2]));
            compare_field("fix_type", 32'(w.fix), 32'(d[10:3]));
            compare_field("satellite_count", 32'(w.sats), 32'(d[18:11]));
            compare_field("latitude", 32'(w.lat), 32'(d[49:19]));
            compare_field("longitude", w.lon, d[81:50]);
            compare_field("sea_level_altitude", w.alt, d[113:82]);
            compare_field("position_dop", 32'(w.dop), 32'(d[129:114]));
            compare_field("velocity_x", w.vel_x, d[161:130]);
            compare_field("velocity_y", w.vel_y, d[193:162]);
            compare_field("velocity_z", w.vel_z, d[225:194]);
        endfunction
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [7:0]              s_tdata = '0;
    logic [0:0]              s_tuser = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [RESULT_WIDTH-1:0] m_tdata;
    logic [0:0]              m_tuser;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [1:0]              cfg_index = '0;
    logic [15:0]             cfg_data = '0;

    nav_report_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int requests_sent = 0;
    int idle_cycles = 0;

    gps_binary_frame_receiver DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
            if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) sb.note_request(s_tuser[0], s_tdata);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_request(input logic cmd, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        push_request(CMD_BYTE, b);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) push_request(CMD_TICK, 8'($urandom_range(255)));
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [15:0] delay, input logic [15:0] timeout,
                             input logic [7:0] id);
        write_reg(CFG_POWER_DELAY, delay);
        write_reg(CFG_LINK_TIMEOUT, timeout);
        write_reg(CFG_NAV_ID, 16'(id));
    endtask

    // flaw: 0 none, 1 corrupt one byte, 2 oversize length, 3 truncate
    task automatic send_frame(input logic [7:0] msg_id, input int len, input int flaw);
        logic [7:0] frame[$];
        logic [7:0] b;
        logic [7:0] fix;
        logic [7:0] cs;
        int k;
        int cut;
        frame = {SYNC_FIRST, SYNC_SECOND, LEN_HIGH, 8'(len)};
        fix = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
        cs = '0;
        for (k = 0; k < len; k++) begin
            b = (k == 0) ? msg_id : (k == 1) ? fix : 8'($urandom_range(255));
            cs = cs ^ b;
            frame.push_back(b);
        end
        frame.push_back(cs);
        frame.push_back(TAIL_FIRST);
        frame.push_back(TAIL_SECOND);
        case (flaw)
            1: begin
                k = $urandom_range(frame.size() - 1);
                frame[k] = frame[k] ^ 8'($urandom_range(1, 255));
            end
            2: frame[3] = 8'($urandom_range(62, 255));
            3: begin
                cut = $urandom_range(1, frame.size() - 1);
                while (frame.size() > cut) void'(frame.pop_back());
            end
            default: ;
        endcase
        foreach (frame[i]) send_byte(frame[i]);
    endtask

    function automatic int pick_length();
        return ($urandom_range(99) < 40) ? $urandom_range(59, 61) : $urandom_range(0, 30);
    endfunction

    initial begin
        logic [15:0] delay_plan[6];
        logic [15:0] timeout_plan[6];
        logic [7:0]  id_plan[6];
        logic [7:0]  id;
        int random_base;
        int phase_end;
        int ph;
        int pick;
        int done_count;
        sb = new();
        delay_plan   = '{16'd3, 16'd0, 16'd7, 16'd1, 16'd2, 16'd4};
        timeout_plan = '{16'd60, 16'd25, 16'hFFFF, 16'd0, 16'd120, 16'd50};
        id_plan      = '{NAV_ID_RESET, 8'h00, 8'hFF, 8'($urandom_range(255)),
                         8'($urandom_range(255)), 8'h55};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 10;
        recv_idle_pct = 46;

        send_byte(8'h00);
        send_ticks(1);
        configure(16'd0, 16'd3, 8'h00);
        send_ticks(2);
        // empty payload: checksum byte lands in the message id slot
        send_frame(8'h00, 0, 0);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(LEN_HIGH);
        send_byte(8'd2);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(TAIL_FIRST);
        send_byte(TAIL_SECOND);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(LEN_HIGH);
        send_byte(8'hFF);
        send_ticks(5);

        random_base = requests_sent;
        for (ph = 0; ph < 6; ph++) begin
            configure(delay_plan[ph], timeout_plan[ph], id_plan[ph]);
            phase_end = random_base + (ph + 1) * 275;
            while (requests_sent < phase_end) begin
                done_count = requests_sent - random_base;
                if (done_count < 550) begin
                    send_idle_pct = 10;
                    recv_idle_pct = 46;
                end else if (done_count < 1100) begin
                    send_idle_pct = 46;
                    recv_idle_pct = 10;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                pick = $urandom_range(99);
                id = ($urandom_range(99) < 85) ? sb.nav_id : 8'($urandom_range(255));
                if (pick < 60) begin
                    send_ticks($urandom_range(2));
                    send_frame(id, pick_length(), 0);
                end else if (pick < 75) begin
                    send_ticks($urandom_range(1, (sb.power_delay > 30 ? 30 :
                                                  int'(sb.power_delay)) + 3));
                end else if (pick < 90) begin
                    send_frame(id, pick_length(), $urandom_range(1, 3));
                end else begin
                    repeat ($urandom_range(1, 8))
                        send_byte(($urandom_range(3) == 0) ? SYNC_FIRST :
                                  8'($urandom_range(255)));
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

>>> gps_binary_frame_receiver.f
src/gbfr_pkg.sv
src/gbfr_framer.sv
src/gbfr_watchdog.sv
src/gps_binary_frame_receiver.sv
src/gbfr_checker.sv
sim/tb_top.sv
